// File: rtl/smht_pkg.sv
// shared constants and types for the membership hash table
`default_nettype none
package smht_pkg;
  localparam int unsigned BucketsDefault = 64;
  localparam int unsigned EntriesDefault = 64;
  localparam int unsigned CountMax = 127;
  localparam int unsigned HashShift = 24;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_CREATE = 2'd1;
  localparam logic [1:0] CMD_BYE    = 2'd2;
  localparam logic [1:0] CMD_REMOVE = 2'd3;

  localparam logic [1:0] ST_ABSENT   = 2'd0;
  localparam logic [1:0] ST_PREVALID = 2'd1;
  localparam logic [1:0] ST_BYE      = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] ssrc;
  } cmd_t;

  typedef struct packed {
    logic       found;
    logic       created;
    logic       full_res;
    logic [5:0] slot;
    logic [1:0] entry_state;
    logic [6:0] member_count;
  } res_t;
endpackage
`default_nettype wire

// File: rtl/ssrc_membership_hash_table.sv
// membership hash table with sorted chains; each entry passed over repeats S_READ and S_CMP
// create of a new key adds a slot scan in S_ALLOC, a write in S_WR2, and S_WR3 mid-chain
// one command in flight in the back end; a two-item queue accepts ahead of it
// the queue pops only when the back end is idle; the chain walk and free-slot scan hold it
// synchronous active-low reset empties the table: bucket heads read as empty, no slot valid
// count is zero after reset
`default_nettype none
module ssrc_membership_hash_table
  import smht_pkg::*;
#(
  parameter int unsigned BUCKETS = BucketsDefault,
  parameter int unsigned ENTRIES = EntriesDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [31:0] in_ssrc,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic        out_found,
  output      logic        out_created,
  output      logic        out_full_res,
  output      logic [5:0]  out_slot,
  output      logic [1:0]  out_entry_state,
  output      logic [6:0]  out_member_count
);
  logic q_valid, q_ready;
  cmd_t q_data;
  res_t res;

  smht_front u_front (.clk, .rst_n, .in_valid, .in_ready, .in_command, .in_ssrc,
    .q_valid, .q_ready, .q_data);

  smht_back #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_back (.clk, .rst_n,
    .q_valid, .q_ready, .q_data, .res_valid(out_valid), .res_ready(out_ready),
    .res_data(res));

  assign out_found = res.found;
  assign out_created = res.created;
  assign out_full_res = res.full_res;
  assign out_slot = res.slot;
  assign out_entry_state = res.entry_state;
  assign out_member_count = res.member_count;
endmodule
`default_nettype wire

// File: rtl/smht_ram.sv
// generic ram with one write port and one registered read port
`default_nettype none
module smht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/smht_front.sv
// front end: accepts commands into a small queue
`default_nettype none
module smht_front
  import smht_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [31:0] in_ssrc,
  output      logic        q_valid,
  input  wire logic        q_ready,
  output      cmd_t        q_data
);
  cmd_t       buf_r [2];
  logic [1:0] cnt_r;
  logic       wp_r, rp_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_data = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= '{command: in_command, ssrc: in_ssrc};
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// File: rtl/smht_back.sv
// back end: chain walk and table update sequencer
`default_nettype none
module smht_back
  import smht_pkg::*;
#(
  parameter int unsigned BUCKETS = BucketsDefault,
  parameter int unsigned ENTRIES = EntriesDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output      logic        q_ready,
  input  wire cmd_t        q_data,
  output      logic        res_valid,
  input  wire logic        res_ready,
  output      res_t        res_data
);
  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned LW = $clog2(ENTRIES + 1);
  localparam logic [LW-1:0] NIL = LW'(ENTRIES);
  localparam int unsigned SW = $clog2(ENTRIES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HEAD  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_ALLOC = 3'd4;
  localparam logic [2:0] S_WR2   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;
  localparam logic [2:0] S_WR3   = 3'd7;

  logic [2:0]    state_r, state_nxt;
  cmd_t          cmd_r;
  logic [BW-1:0] bkt_r;
  logic [LW-1:0] cur_r, prev_r, fresh_r;
  logic [SW-1:0] steps_r;
  logic [EW-1:0] scan_r;
  logic [ENTRIES-1:0] valid_r;
  logic [BUCKETS-1:0] hvalid_r;
  logic [6:0]    members_r;
  res_t          wrk_r;
  res_t          res_r, res_nxt;
  logic          res_valid_r;

  // memories
  logic          key_we;  logic [EW-1:0] key_wa, key_ra; logic [31:0] key_wd, key_rd;
  logic          nx_we;   logic [EW-1:0] nx_wa, nx_ra;   logic [LW-1:0] nx_wd, nx_rd;
  logic          st_we;   logic [EW-1:0] st_wa, st_ra;   logic [1:0] st_wd, st_rd;
  logic          hd_we;   logic [BW-1:0] hd_wa, hd_ra;   logic [LW-1:0] hd_wd, hd_rd;

  smht_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_key (.clk, .we(key_we), .waddr(key_wa),
    .wdata(key_wd), .raddr(key_ra), .rdata(key_rd));
  smht_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_next (.clk, .we(nx_we), .waddr(nx_wa),
    .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
  smht_ram #(.WIDTH(2), .DEPTH(ENTRIES)) u_stat (.clk, .we(st_we), .waddr(st_wa),
    .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));
  smht_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head (.clk, .we(hd_we), .waddr(hd_wa),
    .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));

  logic [31:0] hsum;
  logic [BW-1:0] bkt_nxt;
  logic [LW-1:0] head_q;
  logic hit;
  logic [6:0] mem_dec;

  assign hsum = q_data.ssrc + (q_data.ssrc >> HashShift);
  assign bkt_nxt = BW'(hsum % BUCKETS);
  // head read starts while the command is taken so the head is ready in S_HEAD
  assign hd_ra = (state_r == S_IDLE) ? bkt_nxt : bkt_r;
  assign head_q = hvalid_r[bkt_r] ? hd_rd : NIL;
  assign hit = (cur_r != NIL) && (key_rd == cmd_r.ssrc);
  assign mem_dec = (members_r != 7'd0) ? members_r - 7'd1 : members_r;
  assign q_ready = (state_r == S_IDLE);
  assign res_valid = res_valid_r;
  assign res_data = res_r;
  assign key_ra = cur_r[EW-1:0];
  assign nx_ra = cur_r[EW-1:0];
  assign st_ra = cur_r[EW-1:0];

  always_comb begin
    res_nxt = wrk_r;
    res_nxt.member_count = members_r;
  end

  always_comb begin
    state_nxt = state_r;
    key_we = 1'b0; key_wa = fresh_r[EW-1:0]; key_wd = cmd_r.ssrc;
    nx_we = 1'b0;  nx_wa = prev_r[EW-1:0];   nx_wd = fresh_r;
    st_we = 1'b0;  st_wa = cur_r[EW-1:0];    st_wd = ST_BYE;
    hd_we = 1'b0;  hd_wa = bkt_r;            hd_wd = fresh_r;
    unique case (state_r)
      S_IDLE: if (q_valid) state_nxt = S_HEAD;
      S_HEAD: state_nxt = S_READ;
      S_READ: state_nxt = S_CMP;
      S_CMP: begin
        if (cur_r != NIL && steps_r < SW'(ENTRIES) && key_rd < cmd_r.ssrc) begin
          state_nxt = S_READ;
        end else if (hit) begin
          state_nxt = S_OUT;
          if (cmd_r.command == CMD_BYE) begin
            st_we = 1'b1;
          end else if (cmd_r.command == CMD_REMOVE) begin
            st_we = 1'b1; st_wd = ST_ABSENT;
            if (prev_r == NIL) begin
              hd_we = 1'b1; hd_wd = nx_rd;
            end else begin
              nx_we = 1'b1; nx_wd = nx_rd;
            end
          end
        end else if (cmd_r.command == CMD_CREATE) begin
          state_nxt = S_ALLOC;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_ALLOC: begin
        if (valid_r[scan_r] || fresh_r != NIL) begin
          if (fresh_r != NIL || 32'(scan_r) == ENTRIES - 1) state_nxt = S_WR2;
        end
      end
      S_WR2: begin
        state_nxt = S_OUT;
        if (fresh_r != NIL) begin
          key_we = 1'b1;
          st_we = 1'b1; st_wa = fresh_r[EW-1:0]; st_wd = ST_PREVALID;
          nx_we = 1'b1; nx_wa = fresh_r[EW-1:0];
          nx_wd = (steps_r >= SW'(ENTRIES)) ? NIL : cur_r;
          if (prev_r == NIL) hd_we = 1'b1;
          else state_nxt = S_WR3;
        end
      end
      // link the predecessor to the new entry
      S_WR3: begin
        nx_we = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: if (!res_valid_r || res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        cmd_r <= q_data;
        bkt_r <= bkt_nxt;
        prev_r <= NIL;
        steps_r <= '0;
        scan_r <= '0;
        fresh_r <= NIL;
        wrk_r <= '0;
      end
      S_HEAD: cur_r <= head_q;
      S_CMP: begin
        if (cur_r != NIL && steps_r < SW'(ENTRIES) && key_rd < cmd_r.ssrc) begin
          prev_r <= cur_r;
          cur_r <= nx_rd;
          steps_r <= steps_r + SW'(1);
        end
        wrk_r.found <= hit;
        wrk_r.created <= 1'b0;
        wrk_r.full_res <= 1'b0;
        wrk_r.slot <= hit ? 6'(cur_r) : 6'd0;
        wrk_r.entry_state <= !hit ? ST_ABSENT :
          (cmd_r.command == CMD_BYE) ? ST_BYE :
          (cmd_r.command == CMD_REMOVE) ? ST_ABSENT : st_rd;
      end
      S_ALLOC: begin
        if (fresh_r == NIL && !valid_r[scan_r]) fresh_r <= LW'(scan_r);
        if (32'(scan_r) != ENTRIES - 1) scan_r <= scan_r + EW'(1);
      end
      S_WR2: begin
        if (fresh_r != NIL) begin
          wrk_r.created <= 1'b1;
          wrk_r.slot <= 6'(fresh_r);
          wrk_r.entry_state <= ST_PREVALID;
        end else begin
          wrk_r.full_res <= 1'b1;
        end
      end
      default: ;
    endcase
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      hvalid_r <= '0;
      members_r <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && (!res_valid_r || res_ready)) begin
        res_valid_r <= 1'b1;
        res_r <= res_nxt;
      end else if (res_valid_r && res_ready) begin
        res_valid_r <= 1'b0;
      end
      if (hd_we) hvalid_r[hd_wa] <= 1'b1;
      if (state_r == S_CMP && hit && (cmd_r.command == CMD_BYE ||
          cmd_r.command == CMD_REMOVE)) begin
        members_r <= mem_dec;
        if (cmd_r.command == CMD_REMOVE) valid_r[cur_r[EW-1:0]] <= 1'b0;
      end
      if (state_r == S_WR2 && fresh_r != NIL) begin
        valid_r[fresh_r[EW-1:0]] <= 1'b1;
        if (members_r != 7'(CountMax)) members_r <= members_r + 7'd1;
      end
    end
  end
endmodule
`default_nettype wire
